[rtl/core/adk_pkg.sv]
// Shared types, constants and AES helper functions for the DUKPT key derivation block.
`timescale 1ns / 1ps

package adk_pkg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key_word_0;
        logic [63:0] key_word_1;
        logic [63:0] key_word_2;
        logic [63:0] key_word_3;
        logic [1:0]  key_len;
        logic [1:0]  out_len;
        logic [63:0] init_id;
        logic [63:0] txn_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        chunk_index;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic        last;
    } t_out;

    typedef struct packed {
        logic         bad;
        logic [1:0]   kind;
        logic [255:0] key;
        logic [1:0]   ksz;
        logic [1:0]   osz;
        logic [63:0]  ikid;
        logic [63:0]  txid;
    } t_cmd;

    typedef struct packed {
        logic         start;
        logic [255:0] key;
        logic [1:0]   ksz;
        logic [127:0] blk;
    } t_aes_req;

    typedef struct packed {
        logic         done;
        logic [127:0] res;
    } t_aes_rsp;

    localparam logic [1:0] C_ST_OK     = 2'd0;
    localparam logic [1:0] C_ST_BADARG = 2'd1;
    localparam logic [1:0] C_ST_BADKEY = 2'd2;

    localparam logic [1:0] C_KIND_INIT = 2'd0;
    localparam logic [1:0] C_KIND_TXN  = 2'd1;
    localparam logic [1:0] C_KIND_PEK  = 2'd2;
    localparam logic [1:0] C_KIND_BAD  = 2'd3;

    localparam logic [1:0] C_SZ_128 = 2'd0;
    localparam logic [1:0] C_SZ_192 = 2'd1;
    localparam logic [1:0] C_SZ_256 = 2'd2;
    localparam logic [1:0] C_SZ_BAD = 2'd3;

    localparam logic [15:0] C_USE_INITIAL = 16'h8001;
    localparam logic [15:0] C_USE_DERIVE  = 16'h8002;
    localparam logic [15:0] C_USE_PEK     = 16'h1000;
    localparam logic [15:0] C_ALG_FIXED   = 16'h0002;
    localparam logic [7:0]  C_VERSION     = 8'h01;
    localparam logic [7:0]  C_POLY        = 8'h1b;

    localparam logic [0:255][7:0] C_SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return C_SBOX[b];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? C_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] q);
        logic [7:0] r;
        case (q)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/adk_front.sv]
// Front end: accepts request words, flags bad codes and queues commands for the back end.
`timescale 1ns / 1ps

module adk_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  adk_pkg::t_in  i_data,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop,
    output adk_pkg::t_cmd o_cmd
);

    adk_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    adk_pkg::t_cmd w_cmd;
    logic          w_push, w_pop;

    always_comb begin
        w_cmd.bad  = (i_data.kind == adk_pkg::C_KIND_BAD) ||
                     (i_data.key_len == adk_pkg::C_SZ_BAD) ||
                     (i_data.out_len == adk_pkg::C_SZ_BAD);
        w_cmd.kind = i_data.kind;
        w_cmd.key  = {i_data.key_word_0, i_data.key_word_1,
                      i_data.key_word_2, i_data.key_word_3};
        w_cmd.ksz  = i_data.key_len;
        w_cmd.osz  = i_data.out_len;
        w_cmd.ikid = i_data.init_id;
        w_cmd.txid = i_data.txn_id;
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

[rtl/core/adk_aes_core.sv]
// Iterative AES encryption core: one key-schedule word per cycle, a round once each round key is complete.
`timescale 1ns / 1ps

module adk_aes_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  adk_pkg::t_aes_req i_req,
    output adk_pkg::t_aes_rsp o_rsp
);

    logic         r_run, r_done;
    logic [5:0]   r_i;
    logic [2:0]   r_m;
    logic [3:0]   r_q;
    logic [31:0]  r_kw [8];
    logic [127:0] r_s;
    logic [255:0] r_key;
    logic [1:0]   r_ksz;

    logic [3:0]   w_nk;
    logic [2:0]   w_mlast;
    logic [5:0]   w_total;
    logic [31:0]  w_ref, w_t, w_word;
    logic [127:0] w_rk, w_ns;

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [15:0][7:0] b;
        logic [15:0][7:0] t;
        logic [7:0]       a0, a1, a2, a3, x;
        for (int j = 0; j < 16; j++) begin
            b[15-j] = adk_pkg::sbox(s[8*(15-j) +: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                t[15-(4*c+k)] = b[15-(4*((c+k) & 3)+k)];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[15-4*c];
                a1 = t[14-4*c];
                a2 = t[13-4*c];
                a3 = t[12-4*c];
                x  = a0 ^ a1 ^ a2 ^ a3;
                t[15-4*c] = a0 ^ x ^ adk_pkg::xtime(a0 ^ a1);
                t[14-4*c] = a1 ^ x ^ adk_pkg::xtime(a1 ^ a2);
                t[13-4*c] = a2 ^ x ^ adk_pkg::xtime(a2 ^ a3);
                t[12-4*c] = a3 ^ x ^ adk_pkg::xtime(a3 ^ a0);
            end
        end
        return t;
    endfunction

    always_comb begin
        case (r_ksz)
            adk_pkg::C_SZ_128: begin
                w_nk = 4'd4; w_total = 6'd44; w_ref = r_kw[4];
            end
            adk_pkg::C_SZ_192: begin
                w_nk = 4'd6; w_total = 6'd52; w_ref = r_kw[2];
            end
            default: begin
                w_nk = 4'd8; w_total = 6'd60; w_ref = r_kw[0];
            end
        endcase
        w_mlast = w_nk[2:0] - 3'd1;
        w_t     = r_kw[7];
        if (r_i < {2'b00, w_nk}) begin
            w_word = r_key[{~r_i[2:0], 5'b0} +: 32];
        end else begin
            if (r_m == 3'd0) begin
                w_t = {adk_pkg::sbox(r_kw[7][23:16]) ^ adk_pkg::rcon(r_q),
                       adk_pkg::sbox(r_kw[7][15:8]), adk_pkg::sbox(r_kw[7][7:0]),
                       adk_pkg::sbox(r_kw[7][31:24])};
            end else if (r_ksz == adk_pkg::C_SZ_256 && r_m == 3'd4) begin
                w_t = {adk_pkg::sbox(r_kw[7][31:24]), adk_pkg::sbox(r_kw[7][23:16]),
                       adk_pkg::sbox(r_kw[7][15:8]), adk_pkg::sbox(r_kw[7][7:0])};
            end
            w_word = w_ref ^ w_t;
        end
        w_rk = {r_kw[4], r_kw[5], r_kw[6], r_kw[7]};
        if (r_i == 6'd4) begin
            w_ns = r_s ^ w_rk;
        end else begin
            w_ns = aes_round(r_s, r_i == w_total) ^ w_rk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_key <= i_req.key;
            r_ksz <= i_req.ksz;
            r_s   <= i_req.blk;
            r_i   <= 6'd0;
            r_m   <= 3'd0;
            r_q   <= 4'd0;
        end else if (r_run) begin
            if (r_i != w_total) begin
                for (int j = 0; j < 7; j++) begin
                    r_kw[j] <= r_kw[j+1];
                end
                r_kw[7] <= w_word;
                r_i     <= r_i + 6'd1;
                if (r_m == w_mlast) begin
                    r_m <= 3'd0;
                    r_q <= r_q + 4'd1;
                end else begin
                    r_m <= r_m + 3'd1;
                end
            end
            if (r_i != 6'd0 && r_i[1:0] == 2'b00) begin
                r_s <= w_ns;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
            end else if (r_run && r_i == w_total) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_s;

endmodule

[rtl/core/adk_back.sv]
// Back end: sequences the derivation stages, drives the AES core and registers result words.
`timescale 1ns / 1ps

module adk_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  adk_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output adk_pkg::t_aes_req o_req,
    input  adk_pkg::t_aes_rsp i_rsp,
    output logic              o_valid,
    input  logic              i_stall,
    output adk_pkg::t_out     o_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_ENC  = 3'd2;
    localparam logic [2:0] S_OUT0 = 3'd3;
    localparam logic [2:0] S_OUT1 = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;

    logic [2:0]    r_state, n_state;
    adk_pkg::t_cmd r_cmd, n_cmd;
    logic [255:0]  r_key, n_key, r_out, n_out, w_merged;
    logic [1:0]    r_ksz, n_ksz, r_stage, n_stage, r_st, n_st;
    logic          r_chunk, n_chunk;
    logic          r_ov, n_ov;
    adk_pkg::t_out r_od, n_od;

    logic          w_free, w_zero, w_start, w_start_chunk;
    logic [15:0]   w_usage, w_bits;
    logic [63:0]   w_dat;

    assign w_free = !r_ov || !i_stall;

    always_comb begin
        if (r_stage == 2'd0) begin
            w_usage = (r_cmd.kind == adk_pkg::C_KIND_TXN) ? adk_pkg::C_USE_DERIVE
                                                          : adk_pkg::C_USE_INITIAL;
            w_dat   = (r_cmd.kind == adk_pkg::C_KIND_TXN) ? r_cmd.txid : r_cmd.ikid;
        end else if (r_stage == 2'd1) begin
            w_usage = adk_pkg::C_USE_DERIVE;
            w_dat   = r_cmd.txid;
        end else begin
            w_usage = adk_pkg::C_USE_PEK;
            w_dat   = r_cmd.txid;
        end
        case (r_cmd.osz)
            adk_pkg::C_SZ_128: w_bits = 16'd128;
            adk_pkg::C_SZ_192: w_bits = 16'd192;
            default:           w_bits = 16'd256;
        endcase
        case (r_ksz)
            adk_pkg::C_SZ_128: w_zero = (r_key[255:128] == '0);
            adk_pkg::C_SZ_192: w_zero = (r_key[255:64] == '0);
            default:           w_zero = (r_key == '0);
        endcase
        if (r_chunk) begin
            if (r_cmd.osz == adk_pkg::C_SZ_192) begin
                w_merged = {r_out[255:128], i_rsp.res[127:64], 64'd0};
            end else begin
                w_merged = {r_out[255:128], i_rsp.res};
            end
        end else begin
            w_merged = {i_rsp.res, r_out[127:0]};
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_key         = r_key;
        n_ksz         = r_ksz;
        n_stage       = r_stage;
        n_st          = r_st;
        n_chunk       = r_chunk;
        n_out         = r_out;
        n_od          = r_od;
        o_cmd_pop     = 1'b0;
        w_start       = 1'b0;
        w_start_chunk = 1'b0;
        n_ov          = i_stall ? r_ov : 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_key     = i_cmd.key;
                    n_ksz     = i_cmd.ksz;
                    n_stage   = 2'd0;
                    if (i_cmd.bad) begin
                        n_st    = adk_pkg::C_ST_BADARG;
                        n_state = S_ERR;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (w_zero) begin
                    n_st    = adk_pkg::C_ST_BADKEY;
                    n_state = S_ERR;
                end else begin
                    n_out   = '0;
                    n_chunk = 1'b0;
                    w_start = 1'b1;
                    n_state = S_ENC;
                end
            end
            S_ENC: begin
                if (i_rsp.done) begin
                    n_out = w_merged;
                    if (!r_chunk && r_cmd.osz != adk_pkg::C_SZ_128) begin
                        n_chunk       = 1'b1;
                        w_start       = 1'b1;
                        w_start_chunk = 1'b1;
                    end else if (r_cmd.kind == adk_pkg::C_KIND_PEK && r_stage != 2'd2) begin
                        n_stage = r_stage + 2'd1;
                        n_key   = w_merged;
                        n_ksz   = r_cmd.osz;
                        n_state = S_CHK;
                    end else begin
                        n_state = S_OUT0;
                    end
                end
            end
            S_OUT0: begin
                if (w_free) begin
                    n_ov               = 1'b1;
                    n_od.status        = adk_pkg::C_ST_OK;
                    n_od.chunk_index   = 1'b0;
                    n_od.key_hi        = r_out[255:192];
                    n_od.key_lo        = r_out[191:128];
                    n_od.last          = (r_cmd.osz == adk_pkg::C_SZ_128);
                    n_state = (r_cmd.osz == adk_pkg::C_SZ_128) ? S_IDLE : S_OUT1;
                end
            end
            S_OUT1: begin
                if (w_free) begin
                    n_ov             = 1'b1;
                    n_od.status      = adk_pkg::C_ST_OK;
                    n_od.chunk_index = 1'b1;
                    n_od.key_hi      = r_out[127:64];
                    n_od.key_lo      = r_out[63:0];
                    n_od.last        = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_ERR: begin
                if (w_free) begin
                    n_ov             = 1'b1;
                    n_od.status      = r_st;
                    n_od.chunk_index = 1'b0;
                    n_od.key_hi      = '0;
                    n_od.key_lo      = '0;
                    n_od.last        = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req.start = w_start;
        o_req.key   = r_key;
        o_req.ksz   = r_ksz;
        o_req.blk   = {adk_pkg::C_VERSION, {7'd0, w_start_chunk} + 8'd1, w_usage,
                       adk_pkg::C_ALG_FIXED, w_bits, w_dat};
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_ksz   <= n_ksz;
        r_stage <= n_stage;
        r_st    <= n_st;
        r_chunk <= n_chunk;
        r_out   <= n_out;
        r_od    <= n_od;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule

[rtl/core/aes_dukpt_key_derivation.sv]
// AES DUKPT key derivation: top level joining front queue, back sequencer and AES core.
// Keys are 128, 192 or 256 bits. A request needs one or two AES blocks per stage and
// up to three stages: one for kind 0 or 1, three for the PEK chain.
// One request is worked at a time, limited by the single iterative AES core;
// a two-word queue takes new requests meanwhile.
// Synchronous active-low reset empties the queue and returns the sequencer to idle.
`timescale 1ns / 1ps

module aes_dukpt_key_derivation (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  adk_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output adk_pkg::t_out  o_data
);

    logic              cmd_valid, cmd_pop;
    adk_pkg::t_cmd     cmd;
    adk_pkg::t_aes_req aes_req;
    adk_pkg::t_aes_rsp aes_rsp;

    adk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    adk_aes_core u_aes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (aes_req),
        .o_rsp   (aes_rsp)
    );

    adk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_req       (aes_req),
        .i_rsp       (aes_rsp),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != adk_pkg::C_ST_OK |->
            o_data.last && !o_data.chunk_index && o_data.key_hi == '0 && o_data.key_lo == '0)
        else $error("error word not a single zero word");

    a_second_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.chunk_index |-> o_data.status == adk_pkg::C_ST_OK && o_data.last)
        else $error("second chunk malformed");

endmodule
